// ----- rtl/core/xee_pkg.sv -----
package xee_pkg;

	// character codes
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	// longest expansion of one input word
	localparam int MAX_RESULTS = 12;
	localparam int ENC_BYTES   = 6;
	localparam int LEN_W       = $clog2(MAX_RESULTS + 1);

	// held byte codes
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_AMP  = 2'd1;
	localparam logic [1:0] HELD_HASH = 2'd2;

	// entity texts, first character at index 0
	localparam logic [4:0][7:0] TXT_AMP  = {";", "p", "m", "a", "&"};
	localparam logic [3:0][7:0] TXT_LT   = {";", "t", "l", "&"};
	localparam logic [3:0][7:0] TXT_GT   = {";", "t", "g", "&"};
	localparam logic [5:0][7:0] TXT_QUOT = {";", "t", "o", "u", "q", "&"};
	localparam logic [5:0][7:0] TXT_APOS = {";", "s", "o", "p", "a", "&"};
	localparam logic [2:0][7:0] TXT_REF  = {"x", "#", "&"};

	typedef struct packed {
		logic [1:0] held_count;
		logic       raw_copy_mode;
	} xee_state_t;

	typedef struct packed {
		logic [ENC_BYTES-1:0][7:0] bytes;
		logic [2:0]                len;
	} xee_enc_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [LEN_W-1:0]            len;
		logic                        last;
	} xee_seq_t;

	typedef struct packed {
		logic valid;
		logic run_last;
		logic string_end;
	} xee_buf_stat_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
	endfunction

	// normal escaping of one byte
	function automatic xee_enc_t encode_byte(input logic [7:0] b);
		xee_enc_t e;
		e.bytes = '0;
		e.len   = 3'd1;
		unique case (b)
			CH_AMP: begin
				e.bytes = {8'h00, TXT_AMP};
				e.len   = 3'd5;
			end
			CH_LT: begin
				e.bytes = {16'h0000, TXT_LT};
				e.len   = 3'd4;
			end
			CH_GT: begin
				e.bytes = {16'h0000, TXT_GT};
				e.len   = 3'd4;
			end
			CH_QUOT: begin
				e.bytes = TXT_QUOT;
				e.len   = 3'd6;
			end
			CH_APOS: begin
				e.bytes = TXT_APOS;
				e.len   = 3'd6;
			end
			default: begin
				if (b < CTRL_LIMIT) begin
					e.bytes = {CH_SEMI, hex_digit(b[3:0]), hex_digit(b[7:4]), TXT_REF};
					e.len   = 3'd6;
				end else begin
					e.bytes = {40'h0, b};
					e.len   = 3'd1;
				end
			end
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/core/xee_if.sv -----
interface xee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface xee_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output run_last, output string_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input string_end,
		output ready);
endinterface

// ----- rtl/core/xee_expander.sv -----
module xee_expander (
	input  xee_pkg::xee_state_t st,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output xee_pkg::xee_seq_t   seq,
	output xee_pkg::xee_state_t st_nxt
);
	import xee_pkg::*;

	typedef enum logic [1:0] {PRE_NONE, PRE_AMP, PRE_AMP_HASH, PRE_REF} pre_kind_t;

	pre_kind_t pre_kind;
	logic      use_enc;
	logic      use_raw;
	xee_enc_t  enc;
	xee_enc_t  body;

	assign enc = encode_byte(in_byte);

	// decide prefix, body and next state
	always_comb begin
		pre_kind = PRE_NONE;
		use_enc  = 1'b0;
		use_raw  = 1'b0;
		st_nxt   = st;
		if (st.raw_copy_mode) begin
			if (in_last) begin
				use_enc = 1'b1;
			end else begin
				use_raw = 1'b1;
				if (in_byte == CH_SEMI) st_nxt.raw_copy_mode = 1'b0;
			end
		end else if (st.held_count == HELD_HASH && in_byte == CH_X) begin
			pre_kind             = PRE_REF;
			st_nxt.held_count    = HELD_NONE;
			st_nxt.raw_copy_mode = ~in_last;
		end else if (st.held_count == HELD_AMP && in_byte == CH_HASH && !in_last) begin
			st_nxt.held_count = HELD_HASH;
		end else begin
			if (st.held_count == HELD_AMP) pre_kind = PRE_AMP;
			else if (st.held_count == HELD_HASH) pre_kind = PRE_AMP_HASH;
			if (in_byte == CH_AMP && !in_last) begin
				st_nxt.held_count = HELD_AMP;
			end else begin
				st_nxt.held_count = HELD_NONE;
				use_enc           = 1'b1;
			end
		end
		if (in_last) st_nxt = '0;
	end

	// body bytes after the prefix
	always_comb begin
		if (use_enc) begin
			body = enc;
		end else if (use_raw) begin
			body.bytes = {40'h0, in_byte};
			body.len   = 3'd1;
		end else begin
			body.bytes = '0;
			body.len   = 3'd0;
		end
	end

	// join prefix and body
	always_comb begin
		seq.last = in_last;
		case (pre_kind)
			PRE_AMP: begin
				seq.bytes = {8'h00, body.bytes, TXT_AMP};
				seq.len   = LEN_W'(5) + LEN_W'(body.len);
			end
			PRE_AMP_HASH: begin
				seq.bytes = {body.bytes, CH_HASH, TXT_AMP};
				seq.len   = LEN_W'(6) + LEN_W'(body.len);
			end
			PRE_REF: begin
				seq.bytes = {72'h0, TXT_REF};
				seq.len   = LEN_W'(3);
			end
			default: begin
				seq.bytes = {48'h0, body.bytes};
				seq.len   = LEN_W'(body.len);
			end
		endcase
	end

endmodule

// ----- rtl/core/xee_out_buffer.sv -----
module xee_out_buffer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  xee_pkg::xee_seq_t      seq,
	input  logic                   take,
	output logic [7:0]             out_byte,
	output xee_pkg::xee_buf_stat_t stat
);
	import xee_pkg::*;

	logic [MAX_RESULTS-1:0][7:0] seq_q;
	logic [LEN_W-1:0]            count_q;
	logic                        last_q;

	// byte count, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= seq.len;
		end else if (take) begin
			count_q <= count_q - LEN_W'(1);
		end
	end

	// shift line of pending bytes, head at index 0
	always_ff @(posedge clk) begin
		if (load) begin
			seq_q  <= seq.bytes;
			last_q <= seq.last;
		end else if (take) begin
			seq_q <= {8'h00, seq_q[MAX_RESULTS-1:1]};
		end
	end

	assign out_byte        = seq_q[0];
	assign stat.valid      = (count_q != '0);
	assign stat.run_last   = (count_q == LEN_W'(1));
	assign stat.string_end = (count_q == LEN_W'(1)) && last_q;

endmodule

// ----- rtl/core/xml_entity_escape_encoder.sv -----
// xml entity escape encoder
//
// byte_in carries one string byte per word with in_last on the final byte;
// byte_out carries the escaped text one byte per word. run_last marks the
// final output byte caused by one input word, string_end the final byte
// of the whole string.
//
// each accepted word is expanded in the same cycle into up to twelve bytes
// held in an output shift line; the first byte is offered in the cycle
// after the word is accepted. a plain byte passes at one word per cycle
// while the receiver is ready; a word that expands to more than one byte
// holds the output until all its bytes have left, and the next word is
// taken in the cycle its last byte leaves. a held '&' or "&#" gives no output.
//
// reset empties the output line and clears the held and raw copy state.
// when the receiver stalls, the head byte stays on byte_out and byte_in
// ready stays low until the line can take a new expansion.
module xml_entity_escape_encoder (
	input logic      clk,
	input logic      arst_n,
	xee_in_if.sink   byte_in,
	xee_out_if.source byte_out
);
	import xee_pkg::*;

	xee_state_t    st_q;
	xee_state_t    st_nxt;
	xee_seq_t      seq;
	xee_buf_stat_t stat;
	logic          in_acc;
	logic          out_take;

	assign out_take      = byte_out.valid && byte_out.ready;
	assign byte_in.ready = !stat.valid || (out_take && stat.run_last);
	assign in_acc        = byte_in.valid && byte_in.ready;

	// expansion of the incoming word
	xee_expander u_expander (
		.st      (st_q),
		.in_byte (byte_in.in_byte),
		.in_last (byte_in.in_last),
		.seq     (seq),
		.st_nxt  (st_nxt)
	);

	// held and raw copy state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	// output shift line
	xee_out_buffer u_out_buffer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_acc),
		.seq      (seq),
		.take     (out_take),
		.out_byte (byte_out.out_byte),
		.stat     (stat)
	);

	assign byte_out.valid      = stat.valid;
	assign byte_out.run_last   = stat.run_last;
	assign byte_out.string_end = stat.string_end;

endmodule

// ----- rtl/core/xee_checker.sv -----
module xee_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       string_end
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output word changed");

	// string end only on the last byte of a run
	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string_end without run_last");

	// final byte of a string always gives output next cycle
	a_last_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("final byte produced no output");

	// input taken while output pending only as the run drains
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready && run_last)
		else $error("input ready while output run pending");

endmodule

bind xml_entity_escape_encoder xee_checker u_xee_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_in.valid),
	.in_ready   (byte_in.ready),
	.in_last    (byte_in.in_last),
	.out_valid  (byte_out.valid),
	.out_ready  (byte_out.ready),
	.out_byte   (byte_out.out_byte),
	.run_last   (byte_out.run_last),
	.string_end (byte_out.string_end)
);

// ----- sim/xml_entity_escape_encoder_tb.sv -----
module xml_entity_escape_encoder_tb;

	import xee_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_ITEMS  = 125;
	localparam int DRAIN       = 16;

	// one escaped output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} esc_word_t;

	// one directed input word, with the typed-in escaped text where fix_len is non-zero
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic [3:0]  fix_len;
		logic [95:0] fix_text;
	} stim_row_t;

	localparam int NUM_ROWS = 25;

	stim_row_t dir_rows [0:NUM_ROWS-1] = '{
		'{8'h00,   1'b0, 4'd6, "&#x00;"},
		'{8'h1F,   1'b0, 4'd6, "&#x1F;"},
		'{8'h20,   1'b0, 4'd1, " "},
		'{8'hFF,   1'b1, 4'd1, 96'hFF},
		'{CH_LT,   1'b0, 4'd4, "&lt;"},
		'{CH_GT,   1'b0, 4'd4, "&gt;"},
		'{CH_QUOT, 1'b0, 4'd6, "&quot;"},
		'{CH_APOS, 1'b0, 4'd6, "&apos;"},
		'{CH_AMP,  1'b1, 4'd5, "&amp;"},
		'{CH_AMP,  1'b0, 4'd0, '0},
		'{CH_AMP,  1'b0, 4'd0, '0},
		'{CH_HASH, 1'b0, 4'd0, '0},
		'{"y",     1'b0, 4'd0, '0},
		'{CH_AMP,  1'b0, 4'd0, '0},
		'{CH_HASH, 1'b0, 4'd0, '0},
		'{CH_X,    1'b0, 4'd0, '0},
		'{CH_LT,   1'b0, 4'd0, '0},
		'{CH_SEMI, 1'b0, 4'd0, '0},
		'{CH_AMP,  1'b0, 4'd0, '0},
		'{CH_HASH, 1'b0, 4'd0, '0},
		'{CH_X,    1'b0, 4'd0, '0},
		'{CH_GT,   1'b1, 4'd0, '0},
		'{CH_AMP,  1'b0, 4'd0, '0},
		'{CH_HASH, 1'b0, 4'd0, '0},
		'{CH_X,    1'b1, 4'd0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	xee_in_if  byte_in ();
	xee_out_if byte_out ();

	xml_entity_escape_encoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.byte_out (byte_out)
	);

	// predictor state
	logic [1:0] held_cnt;
	logic       raw_mode;
	logic [7:0] esc_text [$];

	esc_word_t  pending_words [$];
	esc_word_t  head_word;
	logic [7:0] text_q [$];

	bit in_gaps  = 1'b1;
	bit out_gaps = 1'b1;
	bit hold_req = 1'b0;
	int errors   = 0;
	int cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			esc_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? "0" + 8'(v) : "A" + 8'(v) - 8'd10;
	endfunction

	// normal escaping of one byte
	function automatic void escape_plain(input logic [7:0] b);
		case (b)
			CH_AMP:  push_text("&amp;");
			CH_LT:   push_text("&lt;");
			CH_GT:   push_text("&gt;");
			CH_QUOT: push_text("&quot;");
			CH_APOS: push_text("&apos;");
			default: begin
				if (b < CTRL_LIMIT) begin
					push_text("&#x");
					esc_text.push_back(hex_char(b[7:4]));
					esc_text.push_back(hex_char(b[3:0]));
					esc_text.push_back(CH_SEMI);
				end else begin
					esc_text.push_back(b);
				end
			end
		endcase
	endfunction

	// escaped text caused by one input word, with the held and raw copy state
	function automatic void escape_step(input logic [7:0] b, input logic last);
		esc_text.delete();
		if (raw_mode) begin
			if (last) begin
				escape_plain(b);
			end else begin
				esc_text.push_back(b);
				if (b == CH_SEMI)
					raw_mode = 1'b0;
			end
		end else if (held_cnt == HELD_HASH && b == CH_X) begin
			push_text("&#x");
			held_cnt = HELD_NONE;
			if (!last)
				raw_mode = 1'b1;
		end else if (held_cnt == HELD_AMP && b == CH_HASH && !last) begin
			held_cnt = HELD_HASH;
		end else begin
			// flush whatever was held, then treat the byte afresh
			if (held_cnt == HELD_AMP)
				push_text("&amp;");
			else if (held_cnt == HELD_HASH)
				push_text("&amp;#");
			held_cnt = HELD_NONE;
			if (b == CH_AMP && !last)
				held_cnt = HELD_AMP;
			else
				escape_plain(b);
		end
		if (last) begin
			held_cnt = HELD_NONE;
			raw_mode = 1'b0;
		end
	endfunction

	function automatic void queue_expected(input logic last);
		esc_word_t w;
		int n;
		n = esc_text.size();
		for (int i = 0; i < n; i++) begin
			w.out_byte   = esc_text[i];
			w.run_last   = (i == n - 1);
			w.string_end = last && (i == n - 1);
			pending_words.push_back(w);
		end
	endfunction

	// offer one word at the falling edge, predict once it is taken
	task automatic send_word(input logic [7:0] b, input logic last, input logic [3:0] fix_len,
		input logic [95:0] fix_text);
		while (in_gaps && $urandom_range(99) < 24) begin
			byte_in.valid <= 1'b0;
			@(negedge clk);
		end
		byte_in.valid   <= 1'b1;
		byte_in.in_byte <= b;
		byte_in.in_last <= last;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		escape_step(b, last);
		if (fix_len != 4'd0) begin
			esc_text.delete();
			for (int k = 0; k < fix_len; k++)
				esc_text.push_back(fix_text[(fix_len - 1 - k) * 8 +: 8]);
		end
		queue_expected(last);
		@(negedge clk);
	endtask

	// one random string: mostly plain text, entities and references, some noise
	task automatic build_text();
		string hexset;
		string specials;
		int pieces;
		hexset   = "0123456789ABCDEFabcdef";
		specials = "&<>\"'";
		text_q.delete();
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(8, 1))
				text_q.push_back(8'($urandom_range(255)));
			return;
		end
		pieces = $urandom_range(6, 1);
		repeat (pieces) begin
			case ($urandom_range(9))
				0, 1, 2: text_q.push_back(8'($urandom_range(126, 32)));
				3:       text_q.push_back(specials[$urandom_range(4)]);
				4:       text_q.push_back(8'($urandom_range(31)));
				5, 6: begin
					text_q.push_back(CH_AMP);
					text_q.push_back(CH_HASH);
					text_q.push_back(CH_X);
					repeat ($urandom_range(4, 1))
						text_q.push_back(hexset[$urandom_range(21)]);
					if ($urandom_range(4) != 0)
						text_q.push_back(CH_SEMI);
				end
				7: begin
					text_q.push_back(CH_AMP);
					if ($urandom_range(1))
						text_q.push_back(CH_HASH);
					text_q.push_back(8'($urandom_range(126, 32)));
				end
				8:       text_q.push_back(8'($urandom_range(255)));
				default: begin
					text_q.push_back(CH_AMP);
					if ($urandom_range(1))
						text_q.push_back(CH_HASH);
				end
			endcase
		end
	endtask

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		byte_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				byte_out.ready <= 1'b0;
				hold_left--;
			end else begin
				byte_out.ready <= !(out_gaps && $urandom_range(99) < 24);
			end
		end
	end

	// compare each accepted output word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && byte_out.valid && byte_out.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word out_byte=%h run_last=%b string_end=%b", $time,
					byte_out.out_byte, byte_out.run_last, byte_out.string_end);
				errors++;
			end else begin
				head_word = pending_words.pop_front();
				if (byte_out.out_byte !== head_word.out_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						head_word.out_byte, byte_out.out_byte);
					errors++;
				end
				if (byte_out.run_last !== head_word.run_last) begin
					$display("%0t: run_last expected %b actual %b", $time,
						head_word.run_last, byte_out.run_last);
					errors++;
				end
				if (byte_out.string_end !== head_word.string_end) begin
					$display("%0t: string_end expected %b actual %b", $time,
						head_word.string_end, byte_out.string_end);
					errors++;
				end
			end
		end
	end

	// run time guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		int n_items;
		int s;
		byte_in.valid   = 1'b0;
		byte_in.in_byte = 8'h00;
		byte_in.in_last = 1'b0;
		held_cnt = HELD_NONE;
		raw_mode = 1'b0;
		arst_n   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words
		for (int r = 0; r < NUM_ROWS; r++)
			send_word(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].fix_len,
				dir_rows[r].fix_text);

		// random strings
		n_items = 0;
		s = 0;
		while (n_items < RAND_ITEMS) begin
			// full rate on both sides for a stretch
			if (s == 4) begin
				in_gaps  = 1'b0;
				out_gaps = 1'b0;
			end
			if (s == 9) begin
				in_gaps  = 1'b1;
				out_gaps = 1'b1;
			end
			// receiver holds off while words keep coming
			if (s == 12)
				hold_req = 1'b1;
			// sender waits for the output to drain
			if (s == 18) begin
				byte_in.valid <= 1'b0;
				do
					@(negedge clk);
				while (pending_words.size() != 0);
			end
			build_text();
			for (int i = 0; i < text_q.size(); i++)
				send_word(text_q[i], i == text_q.size() - 1, 4'd0, '0);
			n_items += text_q.size();
			s++;
		end
		byte_in.valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0 && pending_words.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
